// ----- rtl/pstrk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pstrk_pkg;

   // fixed field widths
   localparam int OFF_W     = 32;
   localparam int LEN_W     = 19;
   localparam int MODE_W    = 3;
   localparam int KIND_W    = 2;
   localparam int PAGE_W    = 33;   // rounded-up page number of a 32-bit byte offset, no wrap
   localparam int PCNT_W    = 7;    // page count up to 64

   // parameter defaults
   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int MAX_PAGES_DEF   = 64;
   localparam int TABLE_DEPTH_DEF = 16;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CHUNK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UNMATCHED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT    = 2'd3;

   // job classes from the front end
   localparam logic [1:0] CLS_ZERO = 2'd0;
   localparam logic [1:0] CLS_BIG  = 2'd1;
   localparam logic [1:0] CLS_REQ  = 2'd2;
   localparam logic [1:0] CLS_CPL  = 2'd3;

   typedef struct packed {
      logic [1:0]        cls;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic              clean;
      logic              flush;
      logic [MODE_W-1:0] mode;
      logic              reply;
      logic [PAGE_W-1:0] page;    // rounded-up page of offset
      logic [PCNT_W-1:0] pages;   // rounded-up page count of length
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/pstrk_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pstrk_req_if;
   import pstrk_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [OFF_W-1:0]  offset;
   logic [LEN_W-1:0]  length;
   logic              clean_flag;
   logic              flush_flag;
   logic [MODE_W-1:0] lock_mode;
   logic              wants_reply;

   modport source (output valid, cmd, offset, length, clean_flag, flush_flag, lock_mode,
                   wants_reply, input ready);
   modport sink (input valid, cmd, offset, length, clean_flag, flush_flag, lock_mode,
                 wants_reply, output ready);
endinterface

`default_nettype wire

// ----- rtl/pstrk_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pstrk_rsp_if;
   import pstrk_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [OFF_W-1:0]  out_offset;
   logic [LEN_W-1:0]  out_length;
   logic              out_clean;
   logic              out_flush;
   logic [MODE_W-1:0] out_lock_mode;
   logic              last;

   modport source (output valid, kind, out_offset, out_length, out_clean, out_flush,
                   out_lock_mode, last, input ready);
   modport sink (input valid, kind, out_offset, out_length, out_clean, out_flush,
                 out_lock_mode, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pstrk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pstrk_front #(
   parameter int PAGE_BYTES = 4096,
   parameter int MAX_PAGES  = 64
) (
   pstrk_req_if.sink         req_chan,
   input  logic              q_full,
   output logic              q_push,
   output pstrk_pkg::job_type q_job
);
   import pstrk_pkg::*;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam logic [31:0] LEN_LIMIT = 32'(MAX_PAGES * PAGE_BYTES);

   logic [PAGE_W-1:0] off_up;
   logic [LEN_W:0]    len_up;

   assign req_chan.ready = !q_full;
   assign q_push = req_chan.valid && !q_full;

   // page arithmetic assumes a power-of-two page size
   assign off_up = {1'b0, req_chan.offset} + PAGE_W'(PAGE_BYTES - 1);
   assign len_up = {1'b0, req_chan.length} + (LEN_W + 1)'(PAGE_BYTES - 1);

   always_comb begin
      q_job.offset = req_chan.offset;
      q_job.length = req_chan.length;
      q_job.clean  = req_chan.clean_flag;
      q_job.flush  = req_chan.flush_flag;
      q_job.mode   = req_chan.lock_mode;
      q_job.reply  = req_chan.wants_reply;
      q_job.page   = off_up >> PAGE_SHIFT;
      q_job.pages  = PCNT_W'(len_up >> PAGE_SHIFT);
      if (req_chan.cmd) begin
         q_job.cls = CLS_CPL;
      end else if (req_chan.length == '0) begin
         q_job.cls = CLS_ZERO;
      end else if (32'(req_chan.length) > LEN_LIMIT) begin
         q_job.cls = CLS_BIG;
      end else begin
         q_job.cls = CLS_REQ;
      end
   end
endmodule

`default_nettype wire

// ----- rtl/pstrk_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pstrk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pstrk_pkg::job_type push_job,
   input  logic              pop,
   output pstrk_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);
   import pstrk_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

`default_nettype wire

// ----- rtl/pstrk_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pstrk_back #(
   parameter int PAGE_BYTES  = 4096,
   parameter int MAX_PAGES   = 64,
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  pstrk_pkg::job_type q_head,
   output logic              q_pop,
   pstrk_rsp_if.source       rsp_chan
);
   import pstrk_pkg::*;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int FP_W   = PAGE_W - PAGE_SHIFT;
   localparam int PC_W   = $clog2(MAX_PAGES + 1);
   localparam int WORD_W = OFF_W + LEN_W + FP_W + 2 * PC_W;
   localparam int LEFT_LO  = 0;
   localparam int CNT_LO   = PC_W;
   localparam int FIRST_LO = 2 * PC_W;
   localparam int LEN_LO   = 2 * PC_W + FP_W;
   localparam int OFF_LO   = 2 * PC_W + FP_W + LEN_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FREE    = 3'd1;
   localparam logic [2:0] ST_CHUNK   = 3'd2;
   localparam logic [2:0] ST_MATCH   = 3'd3;
   localparam logic [2:0] ST_RESOLVE = 3'd4;
   localparam logic [2:0] ST_ONE     = 3'd5;

   logic [2:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [OFF_W-1:0]  cur_off_ff, cur_off_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [KIND_W-1:0] one_kind_ff, one_kind_in;
   logic [OFF_W-1:0]  one_off_ff, one_off_in;
   logic [LEN_W-1:0]  one_len_ff, one_len_in;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              issued_ff, issued_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [WORD_W-1:0] rd_word_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  hit_rank_ff, hit_rank_in;
   logic [WORD_W-1:0] hit_word_ff, hit_word_in;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]  rank_ff [TABLE_DEPTH];
   logic [IDX_W-1:0]  rank_in [TABLE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [WORD_W-1:0] mem [TABLE_DEPTH];
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_clean_ff, rsp_clean_in;
   logic              rsp_flush_ff, rsp_flush_in;
   logic [MODE_W-1:0] rsp_mode_ff, rsp_mode_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_ok;
   logic              emit;
   logic [FP_W-1:0]   cpl_page;
   logic [FP_W-1:0]   ent_first;
   logic [PC_W-1:0]   ent_cnt;
   logic              ent_match;
   logic [PC_W-1:0]   left_now;
   logic [PC_W-1:0]   left_next;
   logic              big;

   assign out_ok    = !rsp_valid_ff || rsp_chan.ready;
   assign cpl_page  = FP_W'(job_ff.page);
   assign ent_first = rd_word_ff[FIRST_LO +: FP_W];
   assign ent_cnt   = rd_word_ff[CNT_LO +: PC_W];
   assign ent_match = valid_ff[rd_idx_ff] && (cpl_page >= ent_first) &&
                      ({1'b0, cpl_page} < ({1'b0, ent_first} + (FP_W + 1)'(ent_cnt)));
   assign left_now  = hit_word_ff[LEFT_LO +: PC_W];
   assign left_next = (left_now == '0) ? left_now : left_now - 1'b1;
   assign big       = cur_len_ff > PAGE_LEN;

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      cur_off_in  = cur_off_ff;
      cur_len_in  = cur_len_ff;
      one_kind_in = one_kind_ff;
      one_off_in  = one_off_ff;
      one_len_in  = one_len_ff;
      scan_in     = scan_ff;
      issued_in   = issued_ff;
      rd_pend_in  = 1'b0;
      rd_idx_in   = scan_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      hit_word_in = hit_word_ff;
      valid_in    = valid_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = scan_ff;
      wr_data     = {job_ff.offset, job_ff.length, FP_W'(job_ff.page),
                     PC_W'(job_ff.pages), PC_W'(job_ff.pages)};
      q_pop       = 1'b0;
      emit        = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_clean_in = rsp_clean_ff;
      rsp_flush_in = rsp_flush_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               job_in      = q_head;
               cur_off_in  = q_head.offset;
               cur_len_in  = q_head.length;
               one_off_in  = q_head.offset;
               one_len_in  = q_head.length;
               scan_in     = '0;
               issued_in   = 1'b0;
               hit_in      = 1'b0;
               case (q_head.cls)
                  CLS_ZERO: begin
                     one_kind_in = KIND_DONE;
                     state_in    = ST_ONE;
                  end
                  CLS_BIG: begin
                     one_kind_in = KIND_REJECT;
                     state_in    = ST_ONE;
                  end
                  CLS_REQ: begin
                     if (!q_head.reply) begin
                        state_in = ST_CHUNK;
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        one_kind_in = KIND_REJECT;
                        state_in    = ST_ONE;
                     end else begin
                        state_in = ST_FREE;
                     end
                  end
                  default: begin
                     state_in = ST_MATCH;
                  end
               endcase
            end
         end
         ST_FREE: begin
            // lowest free slot takes the new record
            if (!valid_ff[scan_ff]) begin
               wr_en             = 1'b1;
               valid_in[scan_ff] = 1'b1;
               rank_in[scan_ff]  = IDX_W'(count_ff);
               count_in          = count_ff + 1'b1;
               state_in          = ST_CHUNK;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_CHUNK: begin
            if (out_ok) begin
               emit         = 1'b1;
               rsp_kind_in  = KIND_CHUNK;
               rsp_off_in   = cur_off_ff;
               rsp_len_in   = big ? PAGE_LEN : cur_len_ff;
               rsp_clean_in = job_ff.clean;
               rsp_flush_in = job_ff.flush;
               rsp_mode_in  = job_ff.mode;
               rsp_last_in  = !big;
               cur_off_in   = cur_off_ff + OFF_W'(PAGE_BYTES);
               cur_len_in   = cur_len_ff - PAGE_LEN;
               if (!big) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MATCH: begin
            if (!issued_ff) begin
               rd_pend_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
               if (scan_ff == LAST_IDX) begin
                  issued_in = 1'b1;
               end
            end
            if (rd_pend_ff) begin
               if (ent_match && (!hit_ff || rank_ff[rd_idx_ff] < hit_rank_ff)) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_rank_in = rank_ff[rd_idx_ff];
                  hit_word_in = rd_word_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_RESOLVE;
               end
            end
         end
         ST_RESOLVE: begin
            wr_addr = hit_idx_ff;
            wr_data = hit_word_ff;
            wr_data[LEFT_LO +: PC_W] = left_next;
            if (!hit_ff) begin
               one_kind_in = KIND_UNMATCHED;
               one_off_in  = job_ff.offset;
               one_len_in  = '0;
               state_in    = ST_ONE;
            end else if (left_next != '0) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (valid_ff[i] && rank_ff[i] > hit_rank_ff) begin
                     rank_in[i] = rank_ff[i] - 1'b1;
                  end
               end
               valid_in[hit_idx_ff] = 1'b0;
               rank_in[hit_idx_ff]  = '0;
               count_in    = count_ff - 1'b1;
               one_kind_in = KIND_DONE;
               one_off_in  = hit_word_ff[OFF_LO +: OFF_W];
               one_len_in  = hit_word_ff[LEN_LO +: LEN_W];
               state_in    = ST_ONE;
            end
         end
         ST_ONE: begin
            if (out_ok) begin
               emit         = 1'b1;
               rsp_kind_in  = one_kind_ff;
               rsp_off_in   = one_off_ff;
               rsp_len_in   = one_len_ff;
               rsp_clean_in = 1'b0;
               rsp_flush_in = 1'b0;
               rsp_mode_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      cur_off_ff   <= cur_off_in;
      cur_len_ff   <= cur_len_in;
      one_kind_ff  <= one_kind_in;
      one_off_ff   <= one_off_in;
      one_len_ff   <= one_len_in;
      scan_ff      <= scan_in;
      issued_ff    <= issued_in;
      rd_idx_ff    <= rd_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_word_ff  <= hit_word_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_clean_ff <= rsp_clean_in;
      rsp_flush_ff <= rsp_flush_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // entry table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[scan_ff];
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.out_offset    = rsp_off_ff;
   assign rsp_chan.out_length    = rsp_len_ff;
   assign rsp_chan.out_clean     = rsp_clean_ff;
   assign rsp_chan.out_flush     = rsp_flush_ff;
   assign rsp_chan.out_lock_mode = rsp_mode_ff;
   assign rsp_chan.last          = rsp_last_ff;
endmodule

`default_nettype wire

// ----- rtl/page_split_completion_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Page split and completion tracker. Each word on req_chan is either a lock
// request (cmd 0) or a chunk completion (cmd 1). A request is cut into
// page-sized chunk words on rsp_chan, the last one marked; with wants_reply it
// is first recorded in a table of TABLE_DEPTH entries (full table: one reject
// word). A zero-length request gives one done word at once, an oversize one a
// reject word. A completion is matched against the oldest entry whose page
// range holds its rounded-up page; the entry's final page gives one done word
// with the original offset and length, no match gives one unmatched word.
// A tracked request first scans the table for its lowest free slot; a
// completion scans the table memory one entry per cycle. A two-word queue
// lets new words be accepted while the back end works. An output register
// holds each result word until it is taken; while a word waits there the
// back end stalls before its next result word for as long as rsp_chan is
// not ready. PAGE_BYTES must be a power of two. No clearing pass: entries
// are guarded by per-entry valid bits.

module page_split_completion_tracker #(
   parameter int PAGE_BYTES  = pstrk_pkg::PAGE_BYTES_DEF,
   parameter int MAX_PAGES   = pstrk_pkg::MAX_PAGES_DEF,
   parameter int TABLE_DEPTH = pstrk_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pstrk_req_if.sink    req_chan,
   pstrk_rsp_if.source  rsp_chan
);
   import pstrk_pkg::*;

   // classified jobs between front and back
   job_type push_job;
   job_type head_job;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   // front: classify and do page rounding
   pstrk_front #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   // short decoupling queue
   pstrk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: table, chunk generation, completion matching
   pstrk_back #(
      .PAGE_BYTES  (PAGE_BYTES),
      .MAX_PAGES   (MAX_PAGES),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (head_job),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule

`default_nettype wire
